[sv/pmg_pkg.sv]
package pmg_pkg;

	// power modes
	localparam logic [2:0] MODE_FULL     = 3'd0;
	localparam logic [2:0] MODE_STD      = 3'd1;
	localparam logic [2:0] MODE_CONSERVE = 3'd2;
	localparam logic [2:0] MODE_LOW      = 3'd3;
	localparam logic [2:0] MODE_EMRG     = 3'd4;

	// transition cause bits
	localparam logic [2:0] CAUSE_BATTERY  = 3'd1;
	localparam logic [2:0] CAUSE_THERMAL  = 3'd2;
	localparam logic [2:0] CAUSE_CHARGING = 3'd4;

	// item operations
	localparam logic OP_EVALUATE = 1'b0;
	localparam logic OP_CONSUME  = 1'b1;

	// configuration register indexes
	localparam logic [2:0] REG_BATTERY_THRESHOLDS = 3'd0;
	localparam logic [2:0] REG_HYSTERESIS_PCT     = 3'd1;
	localparam logic [2:0] REG_CHARGE_FULL_PCT    = 3'd2;
	localparam logic [2:0] REG_THERMAL_ENTER_MC   = 3'd3;
	localparam logic [2:0] REG_THERMAL_EXIT_MC    = 3'd4;
	localparam logic [2:0] REG_SUSTAIN_TIMES      = 3'd5;
	localparam logic [2:0] REG_FAST_CHARGE_MW     = 3'd6;
	localparam logic [2:0] REG_GATE_MASKS         = 3'd7;

	// upward limit when already in full mode
	localparam logic [8:0] FULL_UP_LIMIT = 9'd100;

	typedef struct packed {
		logic [31:0] battery_thresholds;
		logic [6:0]  hysteresis_pct;
		logic [6:0]  charge_full_pct;
		logic [18:0] thermal_enter_mc;
		logic [18:0] thermal_exit_mc;
		logic [31:0] sustain_times;
		logic [15:0] fast_charge_mw;
		logic [39:0] gate_masks;
	} cfg_t;

	typedef struct packed {
		logic [2:0]  from_mode;
		logic [2:0]  next_mode;
		logic [2:0]  cause;
		logic [7:0]  gate;
		logic [6:0]  level_pct;
		logic [18:0] temp_mc;
	} record_t;

	typedef struct packed {
		logic [2:0]  power_mode;
		logic        thermal_lock;
		logic        hot_seen;
		logic [31:0] sustain_timer;
		logic        record_pending;
		record_t     saved_record;
	} state_t;

	typedef struct packed {
		logic        operation;
		logic [6:0]  level_pct;
		logic [18:0] die_temp_mc;
		logic        on_charger;
		logic [15:0] charge_power_mw;
		logic [15:0] seconds_elapsed;
	} item_t;

	typedef struct packed {
		logic        step_status;
		logic [2:0]  power_mode;
		logic        record_valid;
		record_t     record;
	} result_t;

	// mode that the battery level alone calls for
	function automatic logic [2:0] level_to_mode(input logic [6:0] level,
			input logic [31:0] thr);
		logic [7:0] lvl;
		lvl = {1'b0, level};
		if (lvl <= thr[7:0])
			return MODE_EMRG;
		else if (lvl <= thr[15:8])
			return MODE_LOW;
		else if (lvl <= thr[23:16])
			return MODE_CONSERVE;
		else if (lvl <= thr[31:24])
			return MODE_STD;
		else
			return MODE_FULL;
	endfunction

	// level that must be exceeded to step one mode up
	function automatic logic [8:0] up_limit(input logic [2:0] mode,
			input logic [31:0] thr, input logic [6:0] hyst);
		logic [8:0] h;
		h = {2'b00, hyst};
		case (mode)
			MODE_STD:      return {1'b0, thr[31:24]} + h;
			MODE_CONSERVE: return {1'b0, thr[23:16]} + h;
			MODE_LOW:      return {1'b0, thr[15:8]} + h;
			MODE_EMRG:     return {1'b0, thr[7:0]} + h;
			default:       return FULL_UP_LIMIT;
		endcase
	endfunction

	function automatic logic [7:0] gate_of(input logic [2:0] mode,
			input logic [39:0] gates);
		case (mode)
			MODE_FULL:     return gates[7:0];
			MODE_STD:      return gates[15:8];
			MODE_CONSERVE: return gates[23:16];
			MODE_LOW:      return gates[31:24];
			MODE_EMRG:     return gates[39:32];
			default:       return gates[7:0];
		endcase
	endfunction

	// saturating timer add
	function automatic logic [31:0] timer_add(input logic [31:0] t,
			input logic [15:0] secs);
		logic [32:0] sum;
		sum = {1'b0, t} + {17'd0, secs};
		return sum[32] ? 32'hFFFF_FFFF : sum[31:0];
	endfunction

	function automatic record_t make_record(input logic [2:0] prev,
			input logic [2:0] next, input logic [2:0] cause,
			input logic [39:0] gates, input logic [6:0] level,
			input logic [18:0] temp);
		record_t r;
		r.from_mode = prev;
		r.next_mode = next;
		r.cause     = cause;
		r.gate      = gate_of(next, gates);
		r.level_pct = level;
		r.temp_mc   = temp;
		return r;
	endfunction

endpackage

[sv/power_mode_governor_core.sv]
// Power mode governor. Every item (evaluate readings or consume the pending
// transition record) is captured in an input register, runs through the
// combinational evaluator, and its result is loaded into the result register
// as the item leaves the input register. One item is taken per cycle while the
// result channel does not stall; the limit is the loop from the governor state
// through the evaluator back into that state. A full result register that is
// stalled holds the item in the input register.
// Configuration writes are always ready and take effect on the next cycle.
module power_mode_governor_core (
	input  logic        clk,
	input  logic        arst_n,
	// item channel
	input  logic        req_valid,
	output logic        req_stall,
	input  logic        operation,
	input  logic [6:0]  level_pct,
	input  logic [18:0] die_temp_mc,
	input  logic        on_charger,
	input  logic [15:0] charge_power_mw,
	input  logic [15:0] seconds_elapsed,
	// result channel
	output logic        rsp_valid,
	input  logic        rsp_stall,
	output logic        step_status,
	output logic [2:0]  power_mode,
	output logic        record_valid,
	output logic [2:0]  record_prev_mode,
	output logic [2:0]  record_next_mode,
	output logic [2:0]  record_cause,
	output logic [7:0]  record_gate,
	output logic [6:0]  record_level_pct,
	output logic [18:0] record_temp_mc,
	// configuration channel
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [39:0] cfg_data
);

	pmg_pkg::cfg_t    cfg_q;
	pmg_pkg::state_t  st_q;
	pmg_pkg::state_t  st_nxt;
	pmg_pkg::item_t   item_s1;
	pmg_pkg::result_t res_nxt;
	pmg_pkg::result_t res_q;
	logic             valid_s1;
	logic             rsp_valid_q;
	logic             advance;

	// handshake
	assign advance   = valid_s1 && (!rsp_valid_q || !rsp_stall);
	assign req_stall = valid_s1 && !advance;
	assign cfg_ready = 1'b1;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.battery_thresholds <= 32'h3214_0A05;
			cfg_q.hysteresis_pct     <= 7'd5;
			cfg_q.charge_full_pct    <= 7'd30;
			cfg_q.thermal_enter_mc   <= 19'd45000;
			cfg_q.thermal_exit_mc    <= 19'd40000;
			cfg_q.sustain_times      <= 32'h003C_001E;
			cfg_q.fast_charge_mw     <= 16'd5000;
			cfg_q.gate_masks         <= 40'd0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				pmg_pkg::REG_BATTERY_THRESHOLDS: cfg_q.battery_thresholds <= cfg_data[31:0];
				pmg_pkg::REG_HYSTERESIS_PCT:     cfg_q.hysteresis_pct     <= cfg_data[6:0];
				pmg_pkg::REG_CHARGE_FULL_PCT:    cfg_q.charge_full_pct    <= cfg_data[6:0];
				pmg_pkg::REG_THERMAL_ENTER_MC:   cfg_q.thermal_enter_mc   <= cfg_data[18:0];
				pmg_pkg::REG_THERMAL_EXIT_MC:    cfg_q.thermal_exit_mc    <= cfg_data[18:0];
				pmg_pkg::REG_SUSTAIN_TIMES:      cfg_q.sustain_times      <= cfg_data[31:0];
				pmg_pkg::REG_FAST_CHARGE_MW:     cfg_q.fast_charge_mw     <= cfg_data[15:0];
				pmg_pkg::REG_GATE_MASKS:         cfg_q.gate_masks         <= cfg_data;
				default: ;
			endcase
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!valid_s1 || advance) begin
			valid_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && !req_stall) begin
			item_s1.operation       <= operation;
			item_s1.level_pct       <= level_pct;
			item_s1.die_temp_mc     <= die_temp_mc;
			item_s1.on_charger      <= on_charger;
			item_s1.charge_power_mw <= charge_power_mw;
			item_s1.seconds_elapsed <= seconds_elapsed;
		end
	end

	pmg_eval u_eval (
		.cfg    (cfg_q),
		.st     (st_q),
		.item   (item_s1),
		.st_nxt (st_nxt),
		.res    (res_nxt)
	);

	// governor state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '0;
		end else if (advance) begin
			st_q <= st_nxt;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (advance) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res_nxt;
		end
	end

	assign rsp_valid        = rsp_valid_q;
	assign step_status      = res_q.step_status;
	assign power_mode       = res_q.power_mode;
	assign record_valid     = res_q.record_valid;
	assign record_prev_mode = res_q.record.from_mode;
	assign record_next_mode = res_q.record.next_mode;
	assign record_cause     = res_q.record.cause;
	assign record_gate      = res_q.record.gate;
	assign record_level_pct = res_q.record.level_pct;
	assign record_temp_mc   = res_q.record.temp_mc;

`ifndef SYNTH
	// the lock only engages after a hot reading was seen
	a_lock_hot: assert property (@(posedge clk) disable iff (!arst_n)
		st_q.thermal_lock |-> st_q.hot_seen)
		else $error("thermal lock without hot_seen");

	// mode stays within full to emergency
	a_mode_range: assert property (@(posedge clk) disable iff (!arst_n)
		st_q.power_mode <= pmg_pkg::MODE_EMRG)
		else $error("power mode out of range");

	// a returned record always reports ok status
	a_record_status: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q && res_q.record_valid |-> !res_q.step_status)
		else $error("record returned with no-change status");

	// state only moves when an item leaves the input register
	a_state_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!advance |=> $stable(st_q))
		else $error("governor state changed without an item");
`endif

endmodule

[sv/pmg_eval.sv]
module pmg_eval (
	input  pmg_pkg::cfg_t    cfg,
	input  pmg_pkg::state_t  st,
	input  pmg_pkg::item_t   item,
	output pmg_pkg::state_t  st_nxt,
	output pmg_pkg::result_t res
);

	logic        temp_hot;
	logic        temp_cool;
	logic [31:0] tadd_hot;
	logic [31:0] tadd_lock;
	logic [2:0]  bmode;
	logic [2:0]  mode_v;
	logic [2:0]  lift;
	logic        done;
	logic        status;

	// thermal compares and timer sums
	assign temp_hot  = $signed(item.die_temp_mc) >= $signed(cfg.thermal_enter_mc);
	assign temp_cool = $signed(item.die_temp_mc) < $signed(cfg.thermal_exit_mc);
	assign tadd_hot  = pmg_pkg::timer_add(st.hot_seen ? st.sustain_timer : 32'd0,
		item.seconds_elapsed);
	assign tadd_lock = pmg_pkg::timer_add(st.sustain_timer, item.seconds_elapsed);
	assign bmode     = pmg_pkg::level_to_mode(item.level_pct, cfg.battery_thresholds);

	// charging lift target
	always_comb begin
		if (item.level_pct > cfg.charge_full_pct)
			lift = pmg_pkg::MODE_FULL;
		else if (bmode <= pmg_pkg::MODE_STD)
			lift = pmg_pkg::MODE_STD;
		else
			lift = bmode - 3'd1;
	end

	// one evaluate or consume step
	always_comb begin
		st_nxt = st;
		res    = '0;
		done   = 1'b0;
		status = 1'b1;
		mode_v = st.power_mode;
		if (item.operation == pmg_pkg::OP_EVALUATE) begin
			// thermal override
			if (!st.thermal_lock) begin
				if (temp_hot) begin
					st_nxt.hot_seen      = 1'b1;
					st_nxt.sustain_timer = tadd_hot;
					if (tadd_hot >= {16'd0, cfg.sustain_times[15:0]}) begin
						st_nxt.thermal_lock = 1'b1;
						if (st.power_mode != pmg_pkg::MODE_EMRG) begin
							st_nxt.saved_record = pmg_pkg::make_record(st.power_mode,
								pmg_pkg::MODE_EMRG, pmg_pkg::CAUSE_THERMAL,
								cfg.gate_masks, item.level_pct, item.die_temp_mc);
							st_nxt.power_mode     = pmg_pkg::MODE_EMRG;
							st_nxt.record_pending = 1'b1;
							done   = 1'b1;
							status = 1'b0;
						end
					end
				end else begin
					st_nxt.hot_seen      = 1'b0;
					st_nxt.sustain_timer = 32'd0;
				end
			end else begin
				done = 1'b1;
				if (temp_cool) begin
					st_nxt.sustain_timer = tadd_lock;
					if (tadd_lock >= {16'd0, cfg.sustain_times[31:16]}) begin
						st_nxt.thermal_lock  = 1'b0;
						st_nxt.hot_seen      = 1'b0;
						st_nxt.sustain_timer = 32'd0;
						if (bmode != st.power_mode) begin
							st_nxt.saved_record = pmg_pkg::make_record(st.power_mode,
								bmode, pmg_pkg::CAUSE_BATTERY | pmg_pkg::CAUSE_THERMAL,
								cfg.gate_masks, item.level_pct, item.die_temp_mc);
							st_nxt.power_mode     = bmode;
							st_nxt.record_pending = 1'b1;
							status = 1'b0;
						end
					end
				end else begin
					st_nxt.sustain_timer = 32'd0;
				end
			end
			// battery and charging rules
			if (!done) begin
				if (bmode > st.power_mode) begin
					mode_v = bmode;
				end else if (bmode < st.power_mode &&
						{2'b00, item.level_pct} >
						pmg_pkg::up_limit(st.power_mode, cfg.battery_thresholds,
						cfg.hysteresis_pct)) begin
					mode_v = st.power_mode - 3'd1;
				end
				if (mode_v != st.power_mode) begin
					st_nxt.saved_record = pmg_pkg::make_record(st.power_mode, mode_v,
						pmg_pkg::CAUSE_BATTERY, cfg.gate_masks, item.level_pct,
						item.die_temp_mc);
					st_nxt.power_mode     = mode_v;
					st_nxt.record_pending = 1'b1;
				end
				if (item.on_charger && item.charge_power_mw >= cfg.fast_charge_mw &&
						mode_v != pmg_pkg::MODE_EMRG && mode_v > lift) begin
					st_nxt.saved_record = pmg_pkg::make_record(mode_v, lift,
						pmg_pkg::CAUSE_CHARGING, cfg.gate_masks, item.level_pct,
						item.die_temp_mc);
					st_nxt.power_mode     = lift;
					st_nxt.record_pending = 1'b1;
					status = 1'b0;
				end else begin
					status = !st_nxt.record_pending;
				end
			end
		end else begin
			// consume the pending record
			if (st.record_pending) begin
				res.record_valid      = 1'b1;
				res.record            = st.saved_record;
				st_nxt.record_pending = 1'b0;
				status = 1'b0;
			end
		end
		res.step_status = status;
		res.power_mode  = st_nxt.power_mode;
	end

endmodule
